// ===== rtl/core/sida_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_pkg: shared definitions for the signed integer to decimal text core
// Widths, character codes and the status struct passed between the
// binary to BCD converter and the character emitter.
// ----------------------------------------------------------------------------
package sida_pkg;

   // input integer width
   localparam int INPUT_WIDTH = 32;

   // decimal digits needed for the largest magnitude, 2^(INPUT_WIDTH-1)
   localparam int NUM_DIGITS  = ((INPUT_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int BCD_W       = NUM_DIGITS * 4;

   // counter widths
   localparam int BIT_CNT_W   = $clog2(INPUT_WIDTH + 1);
   localparam int DIG_CNT_W   = $clog2(NUM_DIGITS + 1);

   // character codes
   localparam int            CHAR_W     = 7;
   localparam logic [6:0]    ZERO_CHAR  = 7'h30;
   localparam logic [6:0]    NINE_CHAR  = 7'h39;
   localparam logic [6:0]    MINUS_CHAR = 7'h2D;

   // converter status seen by the emitter
   typedef struct packed {
      logic done;      // BCD result complete and held
      logic negative;  // input was negative
   } conv_status_type;

endpackage

// ===== rtl/core/sida_bcd_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_bcd_conv: bit-serial binary to BCD converter
// Takes the magnitude of a signed integer and runs shift-and-add-3 over it,
// one input bit per cycle, then holds the BCD digits until they are taken.
// ----------------------------------------------------------------------------
module sida_bcd_conv
   import sida_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_valid,
   output logic                          load_stall,
   input  logic signed [INPUT_WIDTH-1:0] load_value,
   output conv_status_type               status,
   output logic [BCD_W-1:0]              bcd,
   input  logic                          take
);

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_RUN,
      CONV_DONE
   } conv_state_type;

   conv_state_type         state_ff, state_in;
   logic [INPUT_WIDTH-1:0] mag_ff, mag_in;
   logic [BCD_W-1:0]       bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic                   neg_ff, neg_in;
   logic [BCD_W-1:0]       adj;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? (bcd_ff[4*i +: 4] + 4'd3)
                                                    : bcd_ff[4*i +: 4];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      case (state_ff)
         CONV_IDLE: begin
            if (load_valid) begin
               neg_in   = load_value[INPUT_WIDTH-1];
               // magnitude as unsigned: most negative value maps to 2^(W-1)
               mag_in   = load_value[INPUT_WIDTH-1]
                          ? ($unsigned(~load_value) + INPUT_WIDTH'(1))
                          : $unsigned(load_value);
               bcd_in   = '0;
               cnt_in   = BIT_CNT_W'(INPUT_WIDTH);
               state_in = CONV_RUN;
            end
         end
         CONV_RUN: begin
            bcd_in = {adj[BCD_W-2:0], mag_ff[INPUT_WIDTH-1]};
            mag_in = {mag_ff[INPUT_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - BIT_CNT_W'(1);
            if (cnt_ff == BIT_CNT_W'(1)) begin
               state_in = CONV_DONE;
            end
         end
         CONV_DONE: begin
            if (take) begin
               state_in = CONV_IDLE;
            end
         end
         default: begin
            state_in = CONV_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
      neg_ff <= neg_in;
   end

   assign load_stall      = (state_ff != CONV_IDLE);
   assign status.done     = (state_ff == CONV_DONE);
   assign status.negative = neg_ff;
   assign bcd             = bcd_ff;

endmodule

// ===== rtl/core/sida_char_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_char_emit: decimal character emitter
// Loads the BCD digits, drops leading zeros one digit per cycle, then sends
// the sign and the digits, most significant first, through an output register.
// ----------------------------------------------------------------------------
module sida_char_emit
   import sida_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  conv_status_type   status,
   input  logic [BCD_W-1:0]  bcd,
   output logic              take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_char_code,
   output logic              rsp_last_char
);

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_SKIP,
      EMIT_SIGN,
      EMIT_DIGIT
   } emit_state_type;

   emit_state_type       state_ff, state_in;
   logic [BCD_W-1:0]     dig_ff, dig_in;
   logic [DIG_CNT_W-1:0] rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic                 valid_ff, valid_in;
   logic [CHAR_W-1:0]    char_ff, char_in;
   logic                 last_ff, last_in;
   logic                 adv;
   logic [3:0]           top_digit;

   assign top_digit = dig_ff[BCD_W-1 -: 4];
   // output register free for a new character
   assign adv       = !valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      dig_in   = dig_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      take     = 1'b0;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         EMIT_IDLE: begin
            if (status.done) begin
               take     = 1'b1;
               dig_in   = bcd;
               neg_in   = status.negative;
               rem_in   = DIG_CNT_W'(NUM_DIGITS);
               state_in = EMIT_SKIP;
            end
         end
         EMIT_SKIP: begin
            // drop leading zeros, keeping at least one digit
            if ((top_digit == 4'd0) && (rem_ff != DIG_CNT_W'(1))) begin
               dig_in = {dig_ff[BCD_W-5:0], 4'b0000};
               rem_in = rem_ff - DIG_CNT_W'(1);
            end else begin
               state_in = neg_ff ? EMIT_SIGN : EMIT_DIGIT;
            end
         end
         EMIT_SIGN: begin
            if (adv) begin
               valid_in = 1'b1;
               char_in  = MINUS_CHAR;
               last_in  = 1'b0;
               state_in = EMIT_DIGIT;
            end
         end
         EMIT_DIGIT: begin
            if (adv) begin
               valid_in = 1'b1;
               char_in  = ZERO_CHAR + {3'b000, top_digit};
               last_in  = (rem_ff == DIG_CNT_W'(1));
               dig_in   = {dig_ff[BCD_W-5:0], 4'b0000};
               rem_in   = rem_ff - DIG_CNT_W'(1);
               if (rem_ff == DIG_CNT_W'(1)) begin
                  state_in = EMIT_IDLE;
               end
            end
         end
         default: begin
            state_in = EMIT_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
         valid_ff <= 1'b0;
         rem_ff   <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         rem_ff   <= rem_in;
      end
      dig_ff  <= dig_in;
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

endmodule

// ===== rtl/core/signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core: signed integer to decimal ASCII text
// Converts one signed integer per request into a run of ASCII characters.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid, req_stall, req_value): one two's complement
//   integer per transfer. Response channel (rsp_valid, rsp_stall,
//   rsp_char_code, rsp_last_char): one character per transfer, most
//   significant first, a leading '-' for negative values, a single '0' for
//   zero; rsp_last_char marks the final character of each number.
//   Sequence: bit-serial BCD conversion over the INPUT_WIDTH input bits, a
//   hand-over to the emitter, leading zeros dropped, then the sign and the
//   digits sent; the zeros dropped and the digits sent add up to NUM_DIGITS.
//   The converter takes a new request once the emitter has taken its result,
//   so one number is converted while the one before is still being sent.
//   Reset clears both units; no output is valid afterwards. While rsp_stall
//   is high the current character holds and the emitter waits; the converter
//   finishes its number and holds it, and req_stall stays high.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core
   import sida_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [INPUT_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CHAR_W-1:0]             rsp_char_code,
   output logic                          rsp_last_char
);

   conv_status_type  conv_status;
   logic [BCD_W-1:0] conv_bcd;
   logic             conv_take;

   // binary to BCD
   sida_bcd_conv u_conv (
      .clock      (clock),
      .reset      (reset),
      .load_valid (req_valid),
      .load_stall (req_stall),
      .load_value (req_value),
      .status     (conv_status),
      .bcd        (conv_bcd),
      .take       (conv_take)
   );

   // character output
   sida_char_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .status        (conv_status),
      .bcd           (conv_bcd),
      .take          (conv_take),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_last_char (rsp_last_char)
   );

endmodule

// ===== rtl/core/sida_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sida_checker: port level checks for the decimal text core
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module sida_checker
   import sida_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [CHAR_W-1:0] rsp_char_code,
   input logic              rsp_last_char
);

   // nothing pending straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled character stays offered
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("response dropped while stalled");

   // an accepted request keeps the converter busy
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && !req_stall) |=> req_stall)
      else $error("request port free right after a transfer");

   // only digits and the minus sign are sent
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid |-> ((rsp_char_code == MINUS_CHAR) ||
                                   ((rsp_char_code >= ZERO_CHAR) &&
                                    (rsp_char_code <= NINE_CHAR))))
      else $error("response is not a decimal character");

   // the sign never ends a number
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && (rsp_char_code == MINUS_CHAR)) |-> !rsp_last_char)
      else $error("minus sign marked as last character");

endmodule

bind signed_int_to_decimal_ascii_core sida_checker u_checker (.*);
